[src/stq_pkg.sv]
// Shared types and codes for the same-track-first request queue.
// No dependencies; imported by stq_cell and the top level.
`default_nettype none

package stq_pkg;

  localparam int TRACK_W   = 16;
  localparam int SECTOR_W  = 8;
  localparam int ARRIVAL_W = 32;
  localparam int OCC_W     = 5;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_GET = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TRACK_W-1:0]   track;
    logic [SECTOR_W-1:0]  sector;
    logic [ARRIVAL_W-1:0] arrival;
  } slot_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic  add_en;     // accepted add that fits
    logic  get_en;     // accepted get on a non-empty queue
    logic  same_mode;  // add track equals the last served track
    slot_t new_slot;
  } stq_ctrl_t;

endpackage

`default_nettype wire

[src/stq_cell.sv]
// One queue slot: holds an entry, decides hold / insert / shift locally.
// Depends on stq_pkg.
`default_nettype none

module stq_cell
  import stq_pkg::*;
(
  input  wire logic      clk,
  input  wire stq_ctrl_t ctrl,
  input  wire logic      occ,          // slot holds a live entry
  input  wire logic      left_ahead,   // left neighbor stays ahead of the insert point
  input  wire logic      run_in,       // all slots to the left are on the add track
  input  wire slot_t     left_data,
  input  wire slot_t     right_data,
  output slot_t          data,
  output logic           ahead,
  output logic           run_out
);

  slot_t data_next;
  logic  match;

  assign match   = occ && (data.track == ctrl.new_slot.track);
  assign run_out = run_in && match;
  // same-track: stay ahead only inside the leading run; otherwise insert at tail
  assign ahead   = ctrl.same_mode ? run_out : occ;

  always_comb begin
    data_next = data;
    priority if (ctrl.add_en) begin
      if (!ahead) begin
        data_next = left_ahead ? ctrl.new_slot : left_data;
      end
    end else if (ctrl.get_en) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

[src/same_track_request_queue_core.sv]
// Top level of the same-track-first request queue: control, cell row, result.
// Depends on stq_pkg and stq_cell.
//
// Usage: drive req_type/req_track/req_sector/req_arrival with start high; the
// beat is taken at a rising edge where start is high and busy is low. busy is
// never raised: one add or get is taken every cycle, back to back.
// Each beat yields exactly one result in the next cycle: done is high for one
// cycle with out_track/out_sector/out_arrival (head entry on a good get, zero
// otherwise), status (ok, get on empty, add on full dropped) and occupancy
// after the beat. The receiver cannot stall; results must be taken as shown.
// Throughput is 1 beat per cycle, set by the row of cells
// that all compare against the add track and shift in the same cycle.
// In same-track mode the insert point comes from a one-bit run flag passed cell to cell.
// Synchronous reset (rst) empties the queue and forgets the served track; slot
// contents are not cleared, only slots below the fill count are ever read.
`default_nettype none

module same_track_request_queue_core
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 req_type,
  input  wire logic [TRACK_W-1:0]   req_track,
  input  wire logic [SECTOR_W-1:0]  req_sector,
  input  wire logic [ARRIVAL_W-1:0] req_arrival,
  output logic                      done,
  output logic [TRACK_W-1:0]        out_track,
  output logic [SECTOR_W-1:0]       out_sector,
  output logic [ARRIVAL_W-1:0]      out_arrival,
  output logic [1:0]                status,
  output logic [OCC_W-1:0]          occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]      count, count_next;
  logic [TRACK_W-1:0] cur_track;
  logic               cur_valid;
  logic               accept, full, empty;
  stq_ctrl_t          ctrl;
  logic [31:0]        count_ext;

  slot_t                  cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ahead_v;
  logic [QUEUE_DEPTH:0]   run_chain;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    ctrl.add_en           = accept && (req_type == REQ_ADD) && !full;
    ctrl.get_en           = accept && (req_type == REQ_GET) && !empty;
    ctrl.same_mode        = cur_valid && (cur_track == req_track);
    ctrl.new_slot.track   = req_track;
    ctrl.new_slot.sector  = req_sector;
    ctrl.new_slot.arrival = req_arrival;
  end

  assign run_chain[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  occ_i;
    logic  left_ahead_i;
    slot_t left_i, right_i;

    assign occ_i = (count > CW'(i));

    if (i == 0) begin : g_first
      assign left_ahead_i = 1'b1;
      assign left_i       = ctrl.new_slot;
    end else begin : g_mid
      assign left_ahead_i = ahead_v[i-1];
      assign left_i       = cell_data[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_i = '0;
    end else begin : g_inner
      assign right_i = cell_data[i+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ_i),
      .left_ahead  (left_ahead_i),
      .run_in      (run_chain[i]),
      .left_data   (left_i),
      .right_data  (right_i),
      .data        (cell_data[i]),
      .ahead       (ahead_v[i]),
      .run_out     (run_chain[i+1])
    );
  end

  always_comb begin
    count_next = count;
    priority if (ctrl.add_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.get_en) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_track <= '0;
      cur_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
      if (ctrl.get_en) begin
        cur_track <= cell_data[0].track;
        cur_valid <= 1'b1;
      end
    end
  end

  assign count_ext = 32'(count_next);

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= count_ext[OCC_W-1:0];
      if (ctrl.get_en) begin
        out_track   <= cell_data[0].track;
        out_sector  <= cell_data[0].sector;
        out_arrival <= cell_data[0].arrival;
      end else begin
        out_track   <= '0;
        out_sector  <= '0;
        out_arrival <= '0;
      end
      priority if ((req_type == REQ_GET) && empty) begin
        status <= STATUS_EMPTY;
      end else if ((req_type == REQ_ADD) && full) begin
        status <= STATUS_FULL;
      end else begin
        status <= STATUS_OK;
      end
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat gave no result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without accepted beat");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == REQ_ADD) && full) |=> $stable(count))
    else $error("add on full queue changed fill count");

  a_get_pops: assert property (@(posedge clk) disable iff (rst)
    ctrl.get_en |=> (count == $past(count) - CW'(1)) && cur_valid)
    else $error("get did not pop the head");

  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_EMPTY)) |-> (out_track == '0) && (out_arrival == '0))
    else $error("payload not zero on get from empty queue");

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for same_track_request_queue_core: directed and random add/get beats.
// Predicts each result with its own queue model; depends on stq_pkg and the RTL.
`timescale 1ns / 100ps

module tb
  import stq_pkg::*;
();

  localparam int QUEUE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BEATS  = 200;
  localparam int PHASE_COUNT  = 8;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 req_type;
  logic [TRACK_W-1:0]   req_track;
  logic [SECTOR_W-1:0]  req_sector;
  logic [ARRIVAL_W-1:0] req_arrival;
  logic                 done;
  logic [TRACK_W-1:0]   out_track;
  logic [SECTOR_W-1:0]  out_sector;
  logic [ARRIVAL_W-1:0] out_arrival;
  logic [1:0]           status;
  logic [OCC_W-1:0]     occupancy;

  typedef struct {
    logic [TRACK_W-1:0]   track;
    logic [SECTOR_W-1:0]  sector;
    logic [ARRIVAL_W-1:0] arrival;
    status_t              code;
    logic [OCC_W-1:0]     occ;
  } queue_result_t;

  // Model of the queue contents and the last served track
  slot_t              queue_model[$];
  logic [TRACK_W-1:0] served_track;
  bit                 served_valid;

  queue_result_t      pending_results[$];
  int                 fail_count;
  int                 cycle_count;
  int                 burst_left;
  bit                 gaps_on;
  logic [TRACK_W-1:0] track_pool[4];

  same_track_request_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .req_track(req_track),
    .req_sector(req_sector),
    .req_arrival(req_arrival),
    .done(done),
    .out_track(out_track),
    .out_sector(out_sector),
    .out_arrival(out_arrival),
    .status(status),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted beat to the model and queue up its result
  task automatic predict_request(input req_type_t kind, input logic [TRACK_W-1:0] trk,
                                 input logic [SECTOR_W-1:0] sec,
                                 input logic [ARRIVAL_W-1:0] arr);
    queue_result_t r;
    slot_t         s;
    int            pos;
    r.track   = '0;
    r.sector  = '0;
    r.arrival = '0;
    r.code    = STATUS_OK;
    if (kind == REQ_ADD) begin
      if (queue_model.size() >= QUEUE_DEPTH) begin
        r.code = STATUS_FULL;
      end else begin
        pos = queue_model.size();
        if (served_valid && served_track == trk) begin
          pos = 0;
          while (pos < queue_model.size() && queue_model[pos].track == trk) pos++;
        end
        s.track   = trk;
        s.sector  = sec;
        s.arrival = arr;
        queue_model.insert(pos, s);
      end
    end else begin
      if (queue_model.size() == 0) begin
        r.code = STATUS_EMPTY;
      end else begin
        s            = queue_model.pop_front();
        served_track = s.track;
        served_valid = 1'b1;
        r.track      = s.track;
        r.sector     = s.sector;
        r.arrival    = s.arrival;
      end
    end
    r.occ = OCC_W'(queue_model.size());
    pending_results.push_back(r);
  endtask

  task automatic send_request(input req_type_t kind, input logic [TRACK_W-1:0] trk,
                              input logic [SECTOR_W-1:0] sec,
                              input logic [ARRIVAL_W-1:0] arr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    req_type    <= kind;
    req_track   <= trk;
    req_sector  <= sec;
    req_arrival <= arr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(kind, trk, sec, arr);
  endtask

  // Payload on a get is don't-care, so keep it random
  task automatic send_get();
    send_request(REQ_GET, TRACK_W'($urandom), SECTOR_W'($urandom), ARRIVAL_W'($urandom));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TRACK_W-1:0] pick_track();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return TRACK_W'($urandom);
    if (roll < 40 && served_valid) return served_track;
    return track_pool[$urandom_range(0, 3)];
  endfunction

  // Nothing served yet: current track must not be treated as valid
  task automatic test_reset_state();
    send_get();
    send_request(REQ_ADD, 16'd7, 8'd1, 32'd100);
    send_request(REQ_ADD, 16'd0, 8'd2, 32'd200);
    send_get();
    send_get();
    send_get();
  endtask

  task automatic test_field_extremes();
    send_request(REQ_ADD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 16'h0000, 8'h00, 32'h0000_0000);
    send_get();
    send_get();
    send_get();
  endtask

  task automatic test_same_track_insert();
    send_request(REQ_ADD, 16'd10, 8'd1, 32'd1);
    send_get();
    // head is on another track: same-track add goes to the head
    send_request(REQ_ADD, 16'd20, 8'd2, 32'd2);
    send_request(REQ_ADD, 16'd10, 8'd3, 32'd3);
    // goes after the leading run of track 10
    send_request(REQ_ADD, 16'd10, 8'd4, 32'd4);
    send_request(REQ_ADD, 16'd30, 8'd5, 32'd5);
    send_request(REQ_ADD, 16'd10, 8'd6, 32'd6);
    repeat (6) send_get();
    // get on empty keeps the served track
    send_request(REQ_ADD, 16'd40, 8'd7, 32'd7);
    send_request(REQ_ADD, 16'd10, 8'd8, 32'd8);
    send_get();
    send_get();
  endtask

  task automatic test_full_queue();
    int i;
    wait_for_results();
    for (i = 0; i < QUEUE_DEPTH + 2; i++)
      send_request(REQ_ADD, track_pool[$urandom_range(0, 1)], SECTOR_W'($urandom),
                   ARRIVAL_W'($urandom));
    for (i = 0; i < QUEUE_DEPTH + 1; i++) send_get();
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int add_pct;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      gaps_on = (phase % 3) != 2;
      case (phase % 4)
        0: add_pct = 55;
        1: add_pct = 80;
        2: add_pct = 45;
        default: add_pct = 25;
      endcase
      track_pool[0] = (phase == 0) ? 16'h0000 : TRACK_W'($urandom);
      track_pool[1] = (phase == 1) ? 16'hFFFF : TRACK_W'($urandom);
      track_pool[2] = TRACK_W'($urandom);
      track_pool[3] = TRACK_W'($urandom);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) < add_pct)
          send_request(REQ_ADD, pick_track(), SECTOR_W'($urandom), ARRIVAL_W'($urandom));
        else
          send_get();
      end
      // hold off until the queue has answered everything
      if (phase == PHASE_COUNT / 2) wait_for_results();
    end
  endtask

  always @(posedge clk) begin : check_results
    queue_result_t r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: track %h status %0d occ %0d",
                 $time, out_track, status, occupancy);
        fail_count++;
      end else begin
        r = pending_results.pop_front();
        if (out_track !== r.track) begin
          $display("%0t: out_track exp %h got %h", $time, r.track, out_track);
          fail_count++;
        end
        if (out_sector !== r.sector) begin
          $display("%0t: out_sector exp %h got %h", $time, r.sector, out_sector);
          fail_count++;
        end
        if (out_arrival !== r.arrival) begin
          $display("%0t: out_arrival exp %h got %h", $time, r.arrival, out_arrival);
          fail_count++;
        end
        if (status !== r.code) begin
          $display("%0t: status exp %0d got %0d", $time, r.code, status);
          fail_count++;
        end
        if (occupancy !== r.occ) begin
          $display("%0t: occupancy exp %0d got %0d", $time, r.occ, occupancy);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("same_track_request_queue_core test failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    req_type      = 1'b0;
    req_track     = '0;
    req_sector    = '0;
    req_arrival   = '0;
    served_track  = '0;
    served_valid  = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    track_pool[0] = 16'h0010;
    track_pool[1] = 16'h0011;
    track_pool[2] = 16'h8000;
    track_pool[3] = 16'hFFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_same_track_insert();
    test_full_queue();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("same_track_request_queue_core test passed");
    else
      $display("same_track_request_queue_core test failed");
    $finish;
  end

endmodule

[files.f]
src/stq_pkg.sv
src/stq_cell.sv
src/same_track_request_queue_core.sv
dv/tb.sv
